// ===== rtl/smwmc_pkg.sv =====
// shared constants, exp tables and control structs for the softmax mean/covariance block
package smwmc_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    // raw weights are at most 2^24 each
    localparam int SUM_W = IDX_W + 25;
    localparam int DIV_W = (SUM_W > 24) ? SUM_W : 24;
    localparam int DVD_W = 56;
    localparam int AX_W = 66;
    localparam int ACC_W = 65 + IDX_W;

    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_START = 5'd1;
    localparam logic [4:0] OP_DIV_T = 5'd2;
    localparam logic [4:0] OP_M1    = 5'd3;
    localparam logic [4:0] OP_M2    = 5'd4;
    localparam logic [4:0] OP_ACC1  = 5'd5;
    localparam logic [4:0] OP_DIV_W = 5'd6;
    localparam logic [4:0] OP_MX    = 5'd7;
    localparam logic [4:0] OP_MY    = 5'd8;
    localparam logic [4:0] OP_AY    = 5'd9;
    localparam logic [4:0] OP_MEAN  = 5'd10;
    localparam logic [4:0] OP_D     = 5'd11;
    localparam logic [4:0] OP_TP    = 5'd12;
    localparam logic [4:0] OP_TH    = 5'd13;
    localparam logic [4:0] OP_TL    = 5'd14;
    localparam logic [4:0] OP_TA    = 5'd15;
    localparam logic [4:0] OP_FIN   = 5'd16;

    localparam logic [24:0] EXPI [16] = '{
        25'd16777216, 25'd6171993, 25'd2270549, 25'd835288, 25'd307285, 25'd113044,
        25'd41587, 25'd15299, 25'd5628, 25'd2070, 25'd762, 25'd280, 25'd103, 25'd38,
        25'd14, 25'd5
    };
    localparam logic [16:0] EXPJ [16] = '{
        17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
        17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
        17'd27319, 17'd25664
    };
    localparam logic [16:0] EXPK [16] = '{
        17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018,
        17'd63768, 17'd63520, 17'd63272, 17'd63025, 17'd62781, 17'd62535, 17'd62291,
        17'd62048, 17'd61806
    };

    typedef struct packed {
        logic [4:0] op;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic idx_last;
        logic term_last;
        logic out_busy;
    } status_t;

endpackage

// ===== rtl/smwmc_div.sv =====
// restoring divider, one quotient bit per cycle
module smwmc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [smwmc_pkg::DVD_W-1:0]    dividend,
    input  logic [smwmc_pkg::DIV_W-1:0]    divisor,
    output logic                           busy,
    output logic [smwmc_pkg::DVD_W-1:0]    quotient
);

    localparam int CW = $clog2(smwmc_pkg::DVD_W + 1);

    logic [smwmc_pkg::DIV_W-1:0] dvs_reg;
    logic [smwmc_pkg::DIV_W-1:0] rem_reg;
    logic [smwmc_pkg::DVD_W-1:0] quo_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic [smwmc_pkg::DIV_W:0]   shifted;
    logic                        fits;

    assign shifted = {rem_reg, quo_reg[smwmc_pkg::DVD_W-1]};
    assign fits = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CW'(smwmc_pkg::DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? smwmc_pkg::DIV_W'(shifted - {1'b0, dvs_reg})
                            : shifted[smwmc_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[smwmc_pkg::DVD_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/smwmc_dp.sv =====
// datapath: point stores, divider, shared multiplier, accumulators and result register
module smwmc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [23:0]          temperature,
    input  logic signed [31:0]   point_x,
    input  logic signed [31:0]   point_y,
    input  logic [23:0]          score,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   mean_x,
    output logic signed [31:0]   mean_y,
    output logic [62:0]          cov_xx,
    output logic signed [63:0]   cov_xy,
    output logic [62:0]          cov_yy,
    output logic [6:0]           point_count,
    output logic                 dropped,
    input  smwmc_pkg::cmd_t      cmd,
    output smwmc_pkg::status_t   status
);

    localparam int IDX_W = smwmc_pkg::IDX_W;
    localparam int CNT_W = smwmc_pkg::CNT_W;
    localparam int SUM_W = smwmc_pkg::SUM_W;
    localparam int DIV_W = smwmc_pkg::DIV_W;
    localparam int DVD_W = smwmc_pkg::DVD_W;
    localparam int AX_W = smwmc_pkg::AX_W;
    localparam int ACC_W = smwmc_pkg::ACC_W;

    logic signed [31:0] x_mem [smwmc_pkg::MAX_POINTS];
    logic signed [31:0] y_mem [smwmc_pkg::MAX_POINTS];
    logic [23:0]        s_mem [smwmc_pkg::MAX_POINTS];
    logic [31:0]        w_mem [smwmc_pkg::MAX_POINTS];

    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [23:0]        rd_s_reg;
    logic [31:0]        rd_w_reg;

    logic [23:0]        temp_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [23:0]        max_reg;
    logic               ovf_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [1:0]         term_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic signed [AX_W-1:0] ax_reg, ay_reg;
    logic [31:0]        w_reg;
    logic signed [31:0] mx_reg, my_reg;
    logic [32:0]        mdx_reg, mdy_reg;
    logic               sdx_reg, sdy_reg;
    logic [31:0]        plo_reg;
    logic [63:0]        hiw_reg;
    logic [65:0]        prod_reg;
    logic [ACC_W-1:0]   accp_reg [3];
    logic [ACC_W-1:0]   accn_reg [3];

    logic               out_valid_reg;
    logic signed [31:0] mean_x_reg, mean_y_reg;
    logic [62:0]        cov_xx_reg, cov_yy_reg;
    logic signed [63:0] cov_xy_reg;
    logic [6:0]         point_count_reg;
    logic               dropped_reg;

    logic               div_start, div_busy;
    logic [DVD_W-1:0]   div_dvd, quo;
    logic [DIV_W-1:0]   div_dvs;
    logic [23:0]        dscore;
    logic               t_big;
    logic [3:0]         ei, ej, ek;
    logic [31:0]        e_val, w_val;
    logic [32:0]        mul_a, mul_b;
    logic [32:0]        xe, ye, absx, absy;
    logic [32:0]        dxe, dye;
    logic [63:0]        m_val;
    logic               term_neg;
    logic               idx_last, term_last, advance;
    logic signed [AX_W-1:0] vx, vy;
    logic signed [ACC_W:0]  dxx, dxy, dyy;
    logic [63:0]        sxx, sxy, syy;

    function automatic logic [31:0] sat_mean(input logic signed [AX_W-1:0] v);
        logic [AX_W-63:0] top;
        top = v[AX_W-1:62];
        if ((&top) || !(|top))
            sat_mean = v[62:31];
        else
            sat_mean = v[AX_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    function automatic logic [63:0] sat_cov(input logic signed [ACC_W:0] v);
        logic [ACC_W-63:0] top;
        top = v[ACC_W:63];
        if ((&top) || !(|top))
            sat_cov = v[63:0];
        else
            sat_cov = v[ACC_W] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    endfunction

    smwmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign dscore = max_reg - rd_s_reg;
    assign div_start = (cmd.op == smwmc_pkg::OP_DIV_T) || (cmd.op == smwmc_pkg::OP_DIV_W);
    assign div_dvd = (cmd.op == smwmc_pkg::OP_DIV_W) ? {rd_w_reg[24:0], 31'd0}
                                                      : DVD_W'({dscore, 16'd0});
    assign div_dvs = (cmd.op == smwmc_pkg::OP_DIV_W) ? DIV_W'(sum_reg)
                   : DIV_W'((temp_reg == 24'd0) ? 24'd1 : temp_reg);

    // t in Q.16; at or above 16.0 the weight is zero
    assign t_big = |quo[DVD_W-1:20];
    assign ei = quo[19:16];
    assign ej = quo[15:12];
    assign ek = quo[11:8];
    assign e_val = t_big ? 32'd0 : {7'd0, prod_reg[40:16]};
    assign w_val = (sum_reg == '0) ? 32'd0 : quo[31:0];

    assign xe = {rd_x_reg[31], rd_x_reg};
    assign ye = {rd_y_reg[31], rd_y_reg};
    assign absx = xe[32] ? (~xe + 33'd1) : xe;
    assign absy = ye[32] ? (~ye + 33'd1) : ye;
    assign dxe = xe - {mx_reg[31], mx_reg};
    assign dye = ye - {my_reg[31], my_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            smwmc_pkg::OP_M1:
            begin
                mul_a = 33'(smwmc_pkg::EXPI[ei]);
                mul_b = 33'(smwmc_pkg::EXPJ[ej]);
            end
            smwmc_pkg::OP_M2:
            begin
                mul_a = 33'(prod_reg[40:16]);
                mul_b = 33'(smwmc_pkg::EXPK[ek]);
            end
            smwmc_pkg::OP_MX:
            begin
                mul_a = 33'(w_val);
                mul_b = absx;
            end
            smwmc_pkg::OP_MY:
            begin
                mul_a = 33'(w_reg);
                mul_b = absy;
            end
            smwmc_pkg::OP_TP:
            begin
                mul_a = (term_reg == 2'd2) ? mdy_reg : mdx_reg;
                mul_b = (term_reg == 2'd0) ? mdx_reg : mdy_reg;
            end
            smwmc_pkg::OP_TH:
            begin
                mul_a = 33'(prod_reg[63:32]);
                mul_b = 33'(w_reg);
            end
            smwmc_pkg::OP_TL:
            begin
                mul_a = 33'(plo_reg);
                mul_b = 33'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // term magnitude, 64-bit wrap as in the product of two magnitudes
    assign m_val = {hiw_reg[62:0], 1'b0} + 64'(prod_reg[63:31]);
    assign term_neg = (term_reg == 2'd1) && (sdx_reg ^ sdy_reg);

    assign idx_last = (idx_reg == IDX_W'(count_reg - CNT_W'(1)));
    assign term_last = (term_reg == 2'd2);
    assign advance = (cmd.op == smwmc_pkg::OP_ACC1) || (cmd.op == smwmc_pkg::OP_AY)
                  || ((cmd.op == smwmc_pkg::OP_TA) && term_last);

    assign vx = ax_reg + AX_W'(64'd1 << 30);
    assign vy = ay_reg + AX_W'(64'd1 << 30);
    assign dxx = $signed({1'b0, accp_reg[0]}) - $signed({1'b0, accn_reg[0]});
    assign dxy = $signed({1'b0, accp_reg[1]}) - $signed({1'b0, accn_reg[1]});
    assign dyy = $signed({1'b0, accp_reg[2]}) - $signed({1'b0, accn_reg[2]});
    assign sxx = sat_cov(dxx);
    assign sxy = sat_cov(dxy);
    assign syy = sat_cov(dyy);

    // stores with registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CNT_W'(smwmc_pkg::MAX_POINTS)))
        begin
            x_mem[count_reg[IDX_W-1:0]] <= point_x;
            y_mem[count_reg[IDX_W-1:0]] <= point_y;
            s_mem[count_reg[IDX_W-1:0]] <= score;
        end
        if (cmd.op == smwmc_pkg::OP_ACC1)
            w_mem[idx_reg] <= e_val;
        else if (cmd.op == smwmc_pkg::OP_MX)
            w_mem[idx_reg] <= w_val;
        rd_x_reg <= x_mem[idx_reg];
        rd_y_reg <= y_mem[idx_reg];
        rd_s_reg <= s_mem[idx_reg];
        rd_w_reg <= w_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg <= 24'd6554;
            count_reg <= '0;
            max_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
            term_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                temp_reg <= temperature;
            if (cmd.load)
            begin
                if (count_reg < CNT_W'(smwmc_pkg::MAX_POINTS))
                begin
                    if ((count_reg == '0) || (score > max_reg))
                        max_reg <= score;
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.op == smwmc_pkg::OP_START)
            begin
                idx_reg <= '0;
                term_reg <= '0;
            end
            else if (advance)
                idx_reg <= idx_last ? '0 : idx_reg + IDX_W'(1);
            if (cmd.op == smwmc_pkg::OP_TA)
                term_reg <= term_last ? 2'd0 : term_reg + 2'd1;
            if (cmd.op == smwmc_pkg::OP_FIN)
            begin
                out_valid_reg <= 1'b1;
                count_reg <= '0;
                max_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            smwmc_pkg::OP_START:
            begin
                sum_reg <= '0;
                ax_reg <= '0;
                ay_reg <= '0;
                for (int t = 0; t < 3; t++)
                begin
                    accp_reg[t] <= '0;
                    accn_reg[t] <= '0;
                end
            end
            smwmc_pkg::OP_ACC1:
                sum_reg <= sum_reg + SUM_W'(e_val);
            smwmc_pkg::OP_MX:
                w_reg <= w_val;
            smwmc_pkg::OP_MY:
                ax_reg <= rd_x_reg[31] ? ax_reg - $signed(AX_W'(prod_reg))
                                       : ax_reg + $signed(AX_W'(prod_reg));
            smwmc_pkg::OP_AY:
                ay_reg <= rd_y_reg[31] ? ay_reg - $signed(AX_W'(prod_reg))
                                       : ay_reg + $signed(AX_W'(prod_reg));
            smwmc_pkg::OP_MEAN:
            begin
                mx_reg <= sat_mean(vx);
                my_reg <= sat_mean(vy);
            end
            smwmc_pkg::OP_D:
            begin
                w_reg <= rd_w_reg;
                sdx_reg <= dxe[32];
                sdy_reg <= dye[32];
                mdx_reg <= dxe[32] ? (~dxe + 33'd1) : dxe;
                mdy_reg <= dye[32] ? (~dye + 33'd1) : dye;
            end
            smwmc_pkg::OP_TH:
                plo_reg <= prod_reg[31:0];
            smwmc_pkg::OP_TL:
                hiw_reg <= prod_reg[63:0];
            smwmc_pkg::OP_TA:
            begin
                if (term_neg)
                    accn_reg[term_reg] <= accn_reg[term_reg] + ACC_W'(m_val);
                else
                    accp_reg[term_reg] <= accp_reg[term_reg] + ACC_W'(m_val);
            end
            smwmc_pkg::OP_FIN:
            begin
                mean_x_reg <= mx_reg;
                mean_y_reg <= my_reg;
                cov_xx_reg <= sxx[63] ? 63'd0 : sxx[62:0];
                cov_xy_reg <= sxy;
                cov_yy_reg <= syy[63] ? 63'd0 : syy[62:0];
                point_count_reg <= 7'(count_reg);
                dropped_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign mean_x = mean_x_reg;
    assign mean_y = mean_y_reg;
    assign cov_xx = cov_xx_reg;
    assign cov_xy = cov_xy_reg;
    assign cov_yy = cov_yy_reg;
    assign point_count = point_count_reg;
    assign dropped = dropped_reg;

    assign status.div_busy = div_busy;
    assign status.idx_last = idx_last;
    assign status.term_last = term_last;
    assign status.out_busy = out_valid_reg;

endmodule

// ===== rtl/smwmc_ctrl.sv =====
// controller: load phase and the three passes over the stored points
module smwmc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last,
    output logic                in_ready,
    output smwmc_pkg::cmd_t     cmd,
    input  smwmc_pkg::status_t  status
);

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_START    = 5'd1;
    localparam logic [4:0] S_P1_RD    = 5'd2;
    localparam logic [4:0] S_P1_DGO   = 5'd3;
    localparam logic [4:0] S_P1_DWAIT = 5'd4;
    localparam logic [4:0] S_P1_M1    = 5'd5;
    localparam logic [4:0] S_P1_M2    = 5'd6;
    localparam logic [4:0] S_P1_ACC   = 5'd7;
    localparam logic [4:0] S_P2_RD    = 5'd8;
    localparam logic [4:0] S_P2_DGO   = 5'd9;
    localparam logic [4:0] S_P2_DWAIT = 5'd10;
    localparam logic [4:0] S_P2_MX    = 5'd11;
    localparam logic [4:0] S_P2_MY    = 5'd12;
    localparam logic [4:0] S_P2_AY    = 5'd13;
    localparam logic [4:0] S_MEAN     = 5'd14;
    localparam logic [4:0] S_P3_RD    = 5'd15;
    localparam logic [4:0] S_P3_D     = 5'd16;
    localparam logic [4:0] S_P3_TP    = 5'd17;
    localparam logic [4:0] S_P3_TH    = 5'd18;
    localparam logic [4:0] S_P3_TL    = 5'd19;
    localparam logic [4:0] S_P3_TA    = 5'd20;
    localparam logic [4:0] S_FIN      = 5'd21;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = smwmc_pkg::OP_NOP;
        cmd.load = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && last)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.op = smwmc_pkg::OP_START;
                state_next = S_P1_RD;
            end
            S_P1_RD:
                state_next = S_P1_DGO;
            S_P1_DGO:
            begin
                cmd.op = smwmc_pkg::OP_DIV_T;
                state_next = S_P1_DWAIT;
            end
            S_P1_DWAIT:
                if (!status.div_busy)
                    state_next = S_P1_M1;
            S_P1_M1:
            begin
                cmd.op = smwmc_pkg::OP_M1;
                state_next = S_P1_M2;
            end
            S_P1_M2:
            begin
                cmd.op = smwmc_pkg::OP_M2;
                state_next = S_P1_ACC;
            end
            S_P1_ACC:
            begin
                cmd.op = smwmc_pkg::OP_ACC1;
                state_next = status.idx_last ? S_P2_RD : S_P1_RD;
            end
            S_P2_RD:
                state_next = S_P2_DGO;
            S_P2_DGO:
            begin
                cmd.op = smwmc_pkg::OP_DIV_W;
                state_next = S_P2_DWAIT;
            end
            S_P2_DWAIT:
                if (!status.div_busy)
                    state_next = S_P2_MX;
            S_P2_MX:
            begin
                cmd.op = smwmc_pkg::OP_MX;
                state_next = S_P2_MY;
            end
            S_P2_MY:
            begin
                cmd.op = smwmc_pkg::OP_MY;
                state_next = S_P2_AY;
            end
            S_P2_AY:
            begin
                cmd.op = smwmc_pkg::OP_AY;
                state_next = status.idx_last ? S_MEAN : S_P2_RD;
            end
            S_MEAN:
            begin
                cmd.op = smwmc_pkg::OP_MEAN;
                state_next = S_P3_RD;
            end
            S_P3_RD:
                state_next = S_P3_D;
            S_P3_D:
            begin
                cmd.op = smwmc_pkg::OP_D;
                state_next = S_P3_TP;
            end
            S_P3_TP:
            begin
                cmd.op = smwmc_pkg::OP_TP;
                state_next = S_P3_TH;
            end
            S_P3_TH:
            begin
                cmd.op = smwmc_pkg::OP_TH;
                state_next = S_P3_TL;
            end
            S_P3_TL:
            begin
                cmd.op = smwmc_pkg::OP_TL;
                state_next = S_P3_TA;
            end
            S_P3_TA:
            begin
                cmd.op = smwmc_pkg::OP_TA;
                if (!status.term_last)
                    state_next = S_P3_TP;
                else
                    state_next = status.idx_last ? S_FIN : S_P3_RD;
            end
            S_FIN:
            begin
                // hold until the previous result has been taken
                if (!status.out_busy)
                begin
                    cmd.op = smwmc_pkg::OP_FIN;
                    state_next = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/softmax_weighted_mean_covariance.sv =====
// top level: softmax-weighted 2d mean and covariance of a point set
//
//  channel   signals                               transfer when
//  cfg       cfg_valid cfg_ready temperature       cfg_valid & cfg_ready
//  in        in_valid in_ready point_x/y score last  in_valid & in_ready
//  out       out_valid out_ready mean/cov/count    out_valid & out_ready
//
// points load one per cycle; after the point marked last the set is processed in
// three passes: a weight pass and a normalize/mean pass, each waiting on the
// serial divider for every point, and a covariance pass that uses the shared
// 33x33 multiplier for each point, plus a start, a mean and a final step.
// no input is taken while a set is processed; reset needs no clearing pass.
// a pending result stalls only the final step of the next set.
module softmax_weighted_mean_covariance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         temperature,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic [23:0]         score,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  mean_x,
    output logic signed [31:0]  mean_y,
    output logic [62:0]         cov_xx,
    output logic signed [63:0]  cov_xy,
    output logic [62:0]         cov_yy,
    output logic [6:0]          point_count,
    output logic                dropped
);

    smwmc_pkg::cmd_t    cmd;
    smwmc_pkg::status_t status;

    smwmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    smwmc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .temperature (temperature),
        .point_x     (point_x),
        .point_y     (point_y),
        .score       (score),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean_x      (mean_x),
        .mean_y      (mean_y),
        .cov_xx      (cov_xx),
        .cov_xy      (cov_xy),
        .cov_yy      (cov_yy),
        .point_count (point_count),
        .dropped     (dropped),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
